// ===== rtl/core/preemptive_priority_scheduler_defines.svh =====
// Assertion macros used by the scheduler back end.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_DEFINES_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define PPS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define PPS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/ppsch_pkg.sv =====
// Shared types and constants of the preemptive priority scheduler.
package ppsch_pkg;

	// Table size default and field widths.
	localparam int MAX_TASKS_DEF = 16;
	localparam int SLOT_W        = 4;
	localparam int TIME_W        = 16;
	localparam int PRIO_W        = 8;
	localparam int CLOCK_W       = 20;
	localparam logic [CLOCK_W-1:0] CLOCK_MAX = {CLOCK_W{1'b1}};

	// Depth of the queue between front and back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic {
		ITEM_LOAD = 1'b0,
		ITEM_TICK = 1'b1
	} item_kind_t;

	// One classified beat as it travels through the queue.
	typedef struct packed {
		item_kind_t        kind;
		logic [SLOT_W-1:0] slot;
		logic [TIME_W-1:0] arrival;
		logic [TIME_W-1:0] burst;
		logic [PRIO_W-1:0] prio;
	} item_t;

	// Queue status seen by both sides.
	typedef struct packed {
		logic empty;
		logic full;
	} fifo_status_t;

	// One task table entry.
	typedef struct packed {
		logic [TIME_W-1:0] arrival;
		logic [TIME_W-1:0] burst;
		logic [TIME_W-1:0] remaining;
		logic [PRIO_W-1:0] prio;
	} slot_entry_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SCAN,
		BK_DRAIN,
		BK_COMMIT,
		BK_REPORT
	} back_state_t;

endpackage

// ===== rtl/core/ppsch_front.sv =====
// Front end: accepts command beats, drops out-of-table loads, feeds the queue.
module ppsch_front import ppsch_pkg::*; #(
	parameter int MAX_TASKS = MAX_TASKS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              action,
	input  logic [SLOT_W-1:0] slot,
	input  logic [TIME_W-1:0] arrival_time,
	input  logic [TIME_W-1:0] burst_length,
	input  logic [PRIO_W-1:0] task_priority,
	input  fifo_status_t      q_stat,
	output logic              push,
	output item_t             push_item
);

	logic  item_v_q;
	item_t item_q;
	logic  accept;
	logic  keep;

	// The held beat stalls only while the queue is full.
	assign push      = item_v_q && !q_stat.full;
	assign busy      = item_v_q && q_stat.full;
	assign accept    = start && !busy;
	assign keep      = action || (32'(slot) < 32'(MAX_TASKS));
	assign push_item = item_q;

	// Occupancy of the front register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_v_q <= 1'b0;
		end else if (accept) begin
			item_v_q <= keep;
		end else if (push) begin
			item_v_q <= 1'b0;
		end
	end

	// Classified payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q.kind    <= action ? ITEM_TICK : ITEM_LOAD;
			item_q.slot    <= slot;
			item_q.arrival <= arrival_time;
			item_q.burst   <= burst_length;
			item_q.prio    <= task_priority;
		end
	end

endmodule

// ===== rtl/core/ppsch_fifo.sv =====
// Short queue of classified beats between the front and back ends.
module ppsch_fifo import ppsch_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  item_t        push_item,
	input  logic         pop,
	output item_t        head,
	output fifo_status_t q_stat
);

	item_t             q_mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign q_stat.empty = (count_q == '0);
	assign q_stat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head         = q_mem[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== rtl/core/ppsch_back.sv =====
// Back end: writes the task table and runs each tick as a serial scan.
`include "preemptive_priority_scheduler_defines.svh"
module ppsch_back import ppsch_pkg::*; #(
	parameter int MAX_TASKS = MAX_TASKS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  item_t              head,
	input  fifo_status_t       q_stat,
	output logic               pop,
	output logic               done,
	output logic               ran,
	output logic [SLOT_W-1:0]  ran_slot,
	output logic               finished,
	output logic [CLOCK_W-1:0] finish_time,
	output logic [CLOCK_W-1:0] turnaround,
	output logic [CLOCK_W-1:0] waiting
);

	localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int SW    = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TASKS - 1);

	back_state_t state_q, state_d;

	// Task table: valid bits in flops, entries in a memory.
	logic [MAX_TASKS-1:0] valid_q;
	slot_entry_t          tbl [MAX_TASKS];

	logic [IDX_W-1:0]   idx_q;
	slot_entry_t        rd_s1;
	logic               rd_valid_s1;
	logic               cmp_v_s1;
	logic [IDX_W-1:0]   cmp_idx_s1;
	logic               best_found_q;
	logic [IDX_W-1:0]   best_idx_q;
	slot_entry_t        best_q;
	logic [CLOCK_W-1:0] clock_q;
	logic               cm_ran_q;
	logic               cm_fin_q;
	logic [CLOCK_W-1:0] cm_tat_q;

	logic               done_q;
	logic               ran_q;
	logic [SLOT_W-1:0]  ran_slot_q;
	logic               finished_q;
	logic [CLOCK_W-1:0] finish_time_q;
	logic [CLOCK_W-1:0] turnaround_q;
	logic [CLOCK_W-1:0] waiting_q;

	logic               tbl_we;
	logic [IDX_W-1:0]   tbl_waddr;
	slot_entry_t        tbl_wdata;
	logic               set_valid;
	logic [SW-1:0]      slot_ext;
	logic [IDX_W-1:0]   load_idx;
	logic [SW-1:0]      best_ext;
	logic               eligible;
	logic [CLOCK_W-1:0] clock_next;
	logic [CLOCK_W-1:0] arr_ext;
	logic [CLOCK_W-1:0] tat;
	logic [TIME_W-1:0]  rem_dec;
	logic [CLOCK_W-1:0] burst_ext;

	assign slot_ext = SW'(head.slot);
	assign load_idx = slot_ext[IDX_W-1:0];
	assign best_ext = SW'(best_idx_q);

	// Candidate test on the entry that was read last cycle.
	assign eligible = cmp_v_s1 && rd_valid_s1
		&& (CLOCK_W'(rd_s1.arrival) <= clock_q)
		&& (rd_s1.remaining != '0)
		&& (!best_found_q || (rd_s1.prio < best_q.prio));

	// Commit arithmetic: the clock saturates at its maximum.
	assign clock_next = (clock_q == CLOCK_MAX) ? clock_q : clock_q + 1'b1;
	assign arr_ext    = CLOCK_W'(best_q.arrival);
	assign tat        = (clock_next >= arr_ext) ? clock_next - arr_ext : '0;
	assign rem_dec    = best_q.remaining - 1'b1;
	assign burst_ext  = CLOCK_W'(best_q.burst);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, queue pop and table write port.
	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		tbl_we    = 1'b0;
		tbl_waddr = load_idx;
		tbl_wdata = '{arrival: head.arrival, burst: head.burst,
			remaining: head.burst, prio: head.prio};
		set_valid = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_stat.empty) begin
					pop = 1'b1;
					if (head.kind == ITEM_TICK) begin
						state_d = BK_SCAN;
					end else begin
						tbl_we    = 1'b1;
						set_valid = 1'b1;
					end
				end
			end
			BK_SCAN: begin
				if (idx_q == LAST_IDX) begin
					state_d = BK_DRAIN;
				end
			end
			BK_DRAIN: begin
				state_d = BK_COMMIT;
			end
			BK_COMMIT: begin
				tbl_we    = best_found_q;
				tbl_waddr = best_idx_q;
				tbl_wdata = '{arrival: best_q.arrival, burst: best_q.burst,
					remaining: rem_dec, prio: best_q.prio};
				state_d   = BK_REPORT;
			end
			BK_REPORT: begin
				state_d = BK_IDLE;
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// Table memory with a registered read port at the scan index.
	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl[tbl_waddr] <= tbl_wdata;
		end
		rd_s1       <= tbl[idx_q];
		rd_valid_s1 <= valid_q[idx_q];
		cmp_idx_s1  <= idx_q;
	end

	// Control: valid bits, scan progress, clock and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			idx_q        <= '0;
			cmp_v_s1     <= 1'b0;
			best_found_q <= 1'b0;
			clock_q      <= '0;
			done_q       <= 1'b0;
		end else begin
			done_q   <= (state_q == BK_REPORT);
			cmp_v_s1 <= (state_q == BK_SCAN);
			if (set_valid) begin
				valid_q[load_idx] <= 1'b1;
			end
			if (state_q == BK_IDLE) begin
				idx_q        <= '0;
				best_found_q <= 1'b0;
			end else if (state_q == BK_SCAN && idx_q != LAST_IDX) begin
				idx_q <= idx_q + 1'b1;
			end
			if (eligible) begin
				best_found_q <= 1'b1;
			end
			if (state_q == BK_COMMIT) begin
				clock_q <= clock_next;
			end
		end
	end

	// Best candidate and per-tick result payload.
	always_ff @(posedge clk) begin
		if (eligible) begin
			best_idx_q <= cmp_idx_s1;
			best_q     <= rd_s1;
		end
		if (state_q == BK_COMMIT) begin
			cm_ran_q <= best_found_q;
			cm_fin_q <= best_found_q && (rem_dec == '0);
			cm_tat_q <= tat;
		end
		if (state_q == BK_REPORT) begin
			ran_q         <= cm_ran_q;
			ran_slot_q    <= cm_ran_q ? best_ext[SLOT_W-1:0] : '0;
			finished_q    <= cm_fin_q;
			finish_time_q <= cm_fin_q ? clock_q : '0;
			turnaround_q  <= cm_fin_q ? cm_tat_q : '0;
			waiting_q     <= (cm_fin_q && cm_tat_q >= burst_ext) ? cm_tat_q - burst_ext : '0;
		end
	end

	assign done        = done_q;
	assign ran         = ran_q;
	assign ran_slot    = ran_slot_q;
	assign finished    = finished_q;
	assign finish_time = finish_time_q;
	assign turnaround  = turnaround_q;
	assign waiting     = waiting_q;

	// Checks on the queue pop, the scan sequencer and the result strobe.
	`PPS_ASSERT_IMP(a_pop_has_data, pop, !q_stat.empty, "pop from an empty queue")
	`PPS_ASSERT_IMP(a_drain_has_data, state_q == BK_DRAIN, cmp_v_s1, "last entry not compared")
	`PPS_ASSERT_NXT(a_report_strobes, state_q == BK_REPORT, done_q, "result not strobed")
	`PPS_ASSERT_NXT(a_strobe_single, done_q, !done_q, "result strobe longer than a cycle")
	`PPS_ASSERT_IMP(a_finish_needs_run, done_q && finished_q, ran_q, "finish without a run")

endmodule

// ===== rtl/core/preemptive_priority_scheduler.sv =====
// Top level of the preemptive priority scheduler.
// A beat is taken when start is high and busy is low. A load beat (action 0)
// writes one task slot and gives no result; a load to a slot at or beyond
// MAX_TASKS is dropped. A tick beat (action 1) gives exactly one result, shown
// for one cycle with done high; the receiver cannot stall it. The table memory
// has one read port, so the back end's scan reads one slot per cycle, then
// finishes the compare, commits the winner and registers the result. A load is
// written in the back end's idle state, without a scan. A two-beat queue sits
// between the front and back ends, so busy rises only when the queue and the
// front register are both full. After reset the table is empty and the clock
// is zero.
module preemptive_priority_scheduler import ppsch_pkg::*; #(
	parameter int MAX_TASKS = MAX_TASKS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               action,
	input  logic [SLOT_W-1:0]  slot,
	input  logic [TIME_W-1:0]  arrival_time,
	input  logic [TIME_W-1:0]  burst_length,
	input  logic [PRIO_W-1:0]  task_priority,
	output logic               done,
	output logic               ran,
	output logic [SLOT_W-1:0]  ran_slot,
	output logic               finished,
	output logic [CLOCK_W-1:0] finish_time,
	output logic [CLOCK_W-1:0] turnaround,
	output logic [CLOCK_W-1:0] waiting
);

	fifo_status_t q_stat;
	logic         push;
	item_t        push_item;
	logic         pop;
	item_t        head;

	// Command intake and classification.
	ppsch_front #(
		.MAX_TASKS(MAX_TASKS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.slot         (slot),
		.arrival_time (arrival_time),
		.burst_length (burst_length),
		.task_priority(task_priority),
		.q_stat       (q_stat),
		.push         (push),
		.push_item    (push_item)
	);

	// Decoupling queue.
	ppsch_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	// Table, scan and result generation.
	ppsch_back #(
		.MAX_TASKS(MAX_TASKS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.q_stat     (q_stat),
		.pop        (pop),
		.done       (done),
		.ran        (ran),
		.ran_slot   (ran_slot),
		.finished   (finished),
		.finish_time(finish_time),
		.turnaround (turnaround),
		.waiting    (waiting)
	);

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the preemptive priority scheduler top level.
`timescale 1ns / 1ps

module testbench;
	import ppsch_pkg::*;

	localparam int RANDOM_BEATS = 1700;
	localparam int IDLE_PERCENT = 21;
	localparam int TICK_CYCLES  = MAX_TASKS_DEF + 4;
	localparam int RUN_LIMIT    = 400000;

	// One tick report as it leaves the block.
	typedef struct packed {
		logic               ran;
		logic [SLOT_W-1:0]  ran_slot;
		logic               finished;
		logic [CLOCK_W-1:0] finish_time;
		logic [CLOCK_W-1:0] turnaround;
		logic [CLOCK_W-1:0] waiting;
	} tick_report_t;

	// Keeps a copy of the task table and the scheduler clock, works out the
	// report of every accepted tick and checks the reports in order.
	class schedule_scoreboard;
		bit [CLOCK_W-1:0] sched_clock;
		bit               task_valid [MAX_TASKS_DEF];
		bit [TIME_W-1:0]  task_arrival [MAX_TASKS_DEF];
		bit [TIME_W-1:0]  task_burst [MAX_TASKS_DEF];
		bit [TIME_W-1:0]  task_left [MAX_TASKS_DEF];
		bit [PRIO_W-1:0]  task_prio [MAX_TASKS_DEF];
		tick_report_t     expected_reports [$];
		int               errors;
		int               loads_taken;
		int               ticks_taken;
		int               reports_seen;
		int               completions_seen;

		function int outstanding();
			return expected_reports.size();
		endfunction

		// Applies one accepted beat to the table; a tick queues its report.
		function void accept_beat(item_t beat);
			int                 winner;
			bit [PRIO_W-1:0]    winner_prio;
			bit [CLOCK_W-1:0]   tat;
			tick_report_t       want;
			want = '0;
			winner = -1;
			winner_prio = '0;
			if (beat.kind == ITEM_LOAD) begin
				loads_taken++;
				if (int'(beat.slot) < MAX_TASKS_DEF) begin
					task_valid[beat.slot] = 1'b1;
					task_arrival[beat.slot] = beat.arrival;
					task_burst[beat.slot] = beat.burst;
					task_left[beat.slot] = beat.burst;
					task_prio[beat.slot] = beat.prio;
				end
				return;
			end
			ticks_taken++;
			// Lowest priority number among ready tasks; the lowest slot keeps a tie.
			for (int k = 0; k < MAX_TASKS_DEF; k++) begin
				if (task_valid[k] && CLOCK_W'(task_arrival[k]) <= sched_clock &&
						task_left[k] != 0 && (winner < 0 || task_prio[k] < winner_prio)) begin
					winner = k;
					winner_prio = task_prio[k];
				end
			end
			if (winner >= 0) begin
				task_left[winner]--;
				want.ran = 1'b1;
				want.ran_slot = SLOT_W'(winner);
			end
			// The clock stops at its maximum.
			if (sched_clock != CLOCK_MAX)
				sched_clock++;
			if (winner >= 0 && task_left[winner] == 0) begin
				tat = (sched_clock >= CLOCK_W'(task_arrival[winner])) ?
					sched_clock - CLOCK_W'(task_arrival[winner]) : '0;
				want.finished = 1'b1;
				want.finish_time = sched_clock;
				want.turnaround = tat;
				want.waiting = (tat >= CLOCK_W'(task_burst[winner])) ?
					tat - CLOCK_W'(task_burst[winner]) : '0;
			end
			expected_reports.push_back(want);
		endfunction

		function void compare_field(string name, logic [CLOCK_W-1:0] want,
				logic [CLOCK_W-1:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		// Checks one report against the oldest tick still waiting.
		function void check_report(tick_report_t got);
			tick_report_t want;
			if (expected_reports.size() == 0) begin
				$display("%0t: report with no tick waiting, expected none, actual slot %0d ran %0d",
					$time, got.ran_slot, got.ran);
				errors++;
				return;
			end
			want = expected_reports.pop_front();
			reports_seen++;
			if (want.finished)
				completions_seen++;
			compare_field("ran", CLOCK_W'(want.ran), CLOCK_W'(got.ran));
			compare_field("ran_slot", CLOCK_W'(want.ran_slot), CLOCK_W'(got.ran_slot));
			compare_field("finished", CLOCK_W'(want.finished), CLOCK_W'(got.finished));
			compare_field("finish_time", want.finish_time, got.finish_time);
			compare_field("turnaround", want.turnaround, got.turnaround);
			compare_field("waiting", want.waiting, got.waiting);
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic               action = 1'b0;
	logic [SLOT_W-1:0]  slot = '0;
	logic [TIME_W-1:0]  arrival_time = '0;
	logic [TIME_W-1:0]  burst_length = '0;
	logic [PRIO_W-1:0]  task_priority = '0;
	logic               done;
	logic               ran;
	logic [SLOT_W-1:0]  ran_slot;
	logic               finished;
	logic [CLOCK_W-1:0] finish_time;
	logic [CLOCK_W-1:0] turnaround;
	logic [CLOCK_W-1:0] waiting;

	bit                 idle_on = 1'b1;
	schedule_scoreboard sched_sb = new;

	preemptive_priority_scheduler i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.action        (action),
		.slot          (slot),
		.arrival_time  (arrival_time),
		.burst_length  (burst_length),
		.task_priority (task_priority),
		.done          (done),
		.ran           (ran),
		.ran_slot      (ran_slot),
		.finished      (finished),
		.finish_time   (finish_time),
		.turnaround    (turnaround),
		.waiting       (waiting)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Run limit well above the slowest legal run.
	initial begin
		repeat (RUN_LIMIT) @(posedge clk);
		$display("Run limit of %0d cycles reached with %0d reports outstanding",
			RUN_LIMIT, sched_sb.outstanding());
		$display("*** FAILED ***");
		$finish;
	end

	// Every strobed report is checked at the edge that ends its cycle.
	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			sched_sb.check_report(tick_report_t'{ran, ran_slot, finished, finish_time,
				turnaround, waiting});
	end

	function automatic item_t make_beat(item_kind_t kind, logic [SLOT_W-1:0] sl,
			logic [TIME_W-1:0] arr, logic [TIME_W-1:0] bur, logic [PRIO_W-1:0] pr);
		item_t beat;
		beat.kind = kind;
		beat.slot = sl;
		beat.arrival = arr;
		beat.burst = bur;
		beat.prio = pr;
		return beat;
	endfunction

	// Mostly short tasks that arrive near the current clock, with a few
	// far arrivals and long bursts so that every field bit is exercised.
	function automatic item_t random_beat();
		item_t beat;
		int    now;
		int    pick;
		int    arr;
		now = int'(sched_sb.sched_clock);
		beat.slot = SLOT_W'($urandom_range(0, 15));
		beat.kind = ($urandom_range(0, 99) < 55) ? ITEM_TICK : ITEM_LOAD;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			arr = $urandom_range(0, now);
		else if (pick < 90)
			arr = now + $urandom_range(1, 12);
		else
			arr = $urandom_range(0, 65535);
		beat.arrival = TIME_W'(arr);
		pick = $urandom_range(0, 99);
		if (pick < 85)
			beat.burst = TIME_W'($urandom_range(1, 8));
		else if (pick < 95)
			beat.burst = TIME_W'($urandom_range(9, 64));
		else
			beat.burst = TIME_W'($urandom_range(1, 65535));
		beat.prio = ($urandom_range(0, 1) == 0) ? PRIO_W'($urandom_range(0, 3)) :
			PRIO_W'($urandom_range(0, 255));
		return beat;
	endfunction

	// Offers one beat, with an occasional gap first, and waits for it to be taken.
	task automatic drive_beat(input item_t beat);
		if (idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
		start <= 1'b1;
		action <= beat.kind;
		slot <= beat.slot;
		arrival_time <= beat.arrival;
		burst_length <= beat.burst;
		task_priority <= beat.prio;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		sched_sb.accept_beat(beat);
	endtask

	task automatic tick_beat();
		drive_beat(make_beat(ITEM_TICK, '0, '0, '0, '0));
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: idle tick on an empty table, tie on priority, preemption,
		// reload of a running task, zero burst, late arrival and field extremes.
		tick_beat();
		drive_beat(make_beat(ITEM_LOAD, 4'd0, 16'd0, 16'd2, 8'd5));
		drive_beat(make_beat(ITEM_LOAD, 4'd15, 16'd0, 16'd1, 8'd5));
		tick_beat();
		tick_beat();
		tick_beat();
		drive_beat(make_beat(ITEM_LOAD, 4'd3, 16'd0, 16'd0, 8'd0));
		drive_beat(make_beat(ITEM_LOAD, 4'd7, 16'hFFFF, 16'hFFFF, 8'hFF));
		drive_beat(make_beat(ITEM_LOAD, 4'd2, 16'd0, 16'd3, 8'd10));
		tick_beat();
		drive_beat(make_beat(ITEM_LOAD, 4'd1, 16'd0, 16'd1, 8'd0));
		tick_beat();
		tick_beat();
		drive_beat(make_beat(ITEM_LOAD, 4'd2, 16'd0, 16'd2, 8'd10));
		tick_beat();
		tick_beat();
		drive_beat(make_beat(ITEM_LOAD, 4'd4, TIME_W'(sched_sb.sched_clock + 2), 16'd1, 8'd0));
		tick_beat();
		tick_beat();
		tick_beat();
		drive_beat(make_beat(ITEM_LOAD, 4'd0, 16'd0, 16'd1, 8'hFF));
		drive_beat(make_beat(ITEM_TICK, 4'd15, 16'hFFFF, 16'hFFFF, 8'hFF));

		// Random traffic with one stretch of back-to-back beats and one
		// pause that lets the block drain completely.
		for (int i = 0; i < RANDOM_BEATS; i++) begin
			idle_on = !(i >= 600 && i < 900);
			if (i == 1000) begin
				start <= 1'b0;
				do
					@(posedge clk);
				while (sched_sb.outstanding() != 0);
			end
			drive_beat(random_beat());
		end
		start <= 1'b0;

		// Drain, then allow time for any stray report to show up.
		while (sched_sb.outstanding() != 0)
			@(posedge clk);
		repeat (3 * TICK_CYCLES) @(posedge clk);

		$display("Covered %0d loads and %0d ticks; %0d reports checked, %0d task completions.",
			sched_sb.loads_taken, sched_sb.ticks_taken, sched_sb.reports_seen,
			sched_sb.completions_seen);
		$display("Scheduler clock ended at %0d with %0d mismatches.",
			sched_sb.sched_clock, sched_sb.errors);
		if (sched_sb.errors == 0 && sched_sb.outstanding() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
